### rtl/terrain_splat_blend_weights_unit_macros.svh
// Assertion macros for the terrain splat blend weights unit
`ifndef TERRAIN_SPLAT_BLEND_WEIGHTS_UNIT_MACROS_SVH
`define TERRAIN_SPLAT_BLEND_WEIGHTS_UNIT_MACROS_SVH

// clocked assertion, off while in reset
`define TSBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion, also checked across reset
`define TSBW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/tsbw_pkg.sv
// Shared types and constants of the terrain splat blend weights unit
`timescale 1ns / 1ps
package tsbw_pkg;

  localparam int WW  = 16;
  localparam int HW  = 24;
  localparam int CW  = 24;
  localparam int IW  = 3;
  localparam int RXW = 27;
  localparam int RDW = 25;
  localparam int RQB = 15;
  localparam int NQB = 16;
  localparam int NRW = 31;
  localparam int NSW = 18;

  localparam logic [WW-1:0] W_ONE     = 16'd32768;
  localparam logic [16:0]   THREE_ONE = 17'd98304;

  typedef logic [IW-1:0] tsbw_idx_t;
  localparam tsbw_idx_t CFG_ROCK_LO   = 3'd0;
  localparam tsbw_idx_t CFG_ROCK_HI   = 3'd1;
  localparam tsbw_idx_t CFG_SNOW_LO   = 3'd2;
  localparam tsbw_idx_t CFG_SNOW_HI   = 3'd3;
  localparam tsbw_idx_t CFG_SAND_TOP  = 3'd4;
  localparam tsbw_idx_t CFG_SAND_WID  = 3'd5;

  typedef struct packed {
    logic            fixed;
    logic [WW-1:0]   tfix;
    logic [RDW-1:0]  rem;
    logic [RDW-1:0]  den;
    logic [RQB-1:0]  q;
  } tsbw_rdiv_t;

  typedef struct packed {
    logic [3:0][NRW-1:0] rem;
    logic [3:0][NQB-1:0] q;
    logic [NSW-1:0]      sum;
    logic                zero;
  } tsbw_ndiv_t;

endpackage

### rtl/tsbw_ramp.sv
// Pipelined smoothstep ramp: band setup, bit-serial divide stages, cubic
`timescale 1ns / 1ps
module tsbw_ramp import tsbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [RXW-1:0] e0,
  input  logic signed [RXW-1:0] e1,
  input  logic signed [RXW-1:0] x,
  output logic                  out_vld,
  output logic [WW-1:0]         s
);

  function automatic tsbw_rdiv_t rdiv_step(tsbw_rdiv_t a);
    logic [RDW:0] r2;
    logic         ge;
    tsbw_rdiv_t   b;
    begin
      b  = a;
      r2 = {a.rem, 1'b0};
      ge = (r2 >= {1'b0, a.den});
      b.rem = ge ? RDW'(r2 - {1'b0, a.den}) : r2[RDW-1:0];
      b.q   = {a.q[RQB-2:0], ge};
      rdiv_step = b;
    end
  endfunction

  logic signed [RXW:0] n_raw, d_raw, n_abs, d_abs;
  tsbw_rdiv_t          st0_nxt;
  tsbw_rdiv_t          st_r   [0:RQB];
  tsbw_rdiv_t          st_nxt [1:RQB];
  logic [WW-1:0]       t_sel;
  logic [WW-1:0]       t_r;
  logic [31:0]         t2_r;
  logic [48:0]         prod;
  logic [WW-1:0]       s_r;
  logic                vld_r [0:RQB+2];

  always_comb begin
    n_raw = (RXW+1)'(x) - (RXW+1)'(e0);
    d_raw = (RXW+1)'(e1) - (RXW+1)'(e0);
    if (d_raw < 0) begin
      n_abs = -n_raw;
      d_abs = -d_raw;
    end else begin
      n_abs = n_raw;
      d_abs = d_raw;
    end
    st0_nxt.fixed = 1'b1;
    st0_nxt.tfix  = '0;
    st0_nxt.rem   = '0;
    st0_nxt.den   = d_abs[RDW-1:0];
    st0_nxt.q     = '0;
    if (e0 == e1) begin
      st0_nxt.tfix = (x < e0) ? '0 : W_ONE;
    end else if (n_abs <= 0) begin
      st0_nxt.tfix = '0;
    end else if (n_abs >= d_abs) begin
      st0_nxt.tfix = W_ONE;
    end else begin
      st0_nxt.fixed = 1'b0;
      st0_nxt.rem   = n_abs[RDW-1:0];
    end
  end

  always_comb begin
    for (int i = 1; i <= RQB; i++) begin
      st_nxt[i] = rdiv_step(st_r[i-1]);
    end
  end

  assign t_sel = st_r[RQB].fixed ? st_r[RQB].tfix : {1'b0, st_r[RQB].q};
  assign prod  = {17'b0, t2_r} * {32'b0, THREE_ONE - {t_r, 1'b0}};

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
      for (int i = 1; i <= RQB; i++) begin
        st_r[i] <= st_nxt[i];
      end
      t_r  <= t_sel;
      t2_r <= {16'b0, t_sel} * {16'b0, t_sel};
      s_r  <= prod[45:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= RQB+2; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= RQB+2; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[RQB+2];
  assign s       = s_r;

endmodule

### rtl/tsbw_mix.sv
// Weight mixing: rock, gated snow and sand, clamped grass and weight sum
`timescale 1ns / 1ps
module tsbw_mix import tsbw_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [WW-1:0]  sr,
  input  logic [WW-1:0]  ss,
  input  logic [WW-1:0]  sd,
  output logic           out_vld,
  output logic [3:0][WW-1:0] w,
  output logic [NSW-1:0] sum
);

  logic [WW-1:0]  rock_a_r, snow_a_r, fall_a_r, nrock_a_r;
  logic [31:0]    snow_prod;
  logic [31:0]    p_b_r;
  logic [WW-1:0]  rock_b_r, snow_b_r, nsnow_b_r;
  logic [47:0]    sand_prod;
  logic [WW-1:0]  rock_c_r, snow_c_r, sand_c_r;
  logic signed [18:0] g;
  logic [WW-1:0]  grass;
  logic [3:0][WW-1:0] w_r;
  logic [NSW-1:0] sum_r;
  logic [3:0]     vld_r;

  assign snow_prod = {16'b0, ss} * {16'b0, sr};
  assign sand_prod = {16'b0, p_b_r} * {32'b0, nsnow_b_r};

  always_comb begin
    g = 19'(W_ONE) - 19'(rock_c_r) - 19'(snow_c_r) - 19'(sand_c_r);
    grass = (g < 0) ? '0 : g[WW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rock_a_r  <= W_ONE - sr;
      nrock_a_r <= sr;
      snow_a_r  <= snow_prod[30:15];
      fall_a_r  <= W_ONE - sd;
      p_b_r     <= {16'b0, fall_a_r} * {16'b0, nrock_a_r};
      rock_b_r  <= rock_a_r;
      snow_b_r  <= snow_a_r;
      nsnow_b_r <= W_ONE - snow_a_r;
      rock_c_r  <= rock_b_r;
      snow_c_r  <= snow_b_r;
      sand_c_r  <= sand_prod[45:30];
      w_r[0]    <= grass;
      w_r[1]    <= rock_c_r;
      w_r[2]    <= snow_c_r;
      w_r[3]    <= sand_c_r;
      sum_r     <= NSW'(grass) + NSW'(rock_c_r) + NSW'(snow_c_r) + NSW'(sand_c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign out_vld = vld_r[3];
  assign w       = w_r;
  assign sum     = sum_r;

endmodule

### rtl/tsbw_norm.sv
// Normalization: four rounded divides by the weight sum, one quotient bit a stage
`timescale 1ns / 1ps
module tsbw_norm import tsbw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [3:0][WW-1:0] w_in,
  input  logic [NSW-1:0]     sum,
  output logic               out_vld,
  output logic [3:0][WW-1:0] w_out
);

  localparam int SHW = NRW + 3;

  function automatic tsbw_ndiv_t ndiv_step(tsbw_ndiv_t a, int k);
    logic [SHW-1:0] sh;
    logic [SHW-1:0] rx;
    logic           ge;
    tsbw_ndiv_t     b;
    begin
      b  = a;
      sh = SHW'(a.sum) << k;
      for (int l = 0; l < 4; l++) begin
        rx = SHW'(a.rem[l]);
        ge = (rx >= sh);
        b.rem[l] = ge ? NRW'(rx - sh) : a.rem[l];
        b.q[l]   = {a.q[l][NQB-2:0], ge};
      end
      ndiv_step = b;
    end
  endfunction

  tsbw_ndiv_t st0_nxt;
  tsbw_ndiv_t st_r   [0:NQB];
  tsbw_ndiv_t st_nxt [1:NQB];
  logic       vld_r  [0:NQB];

  always_comb begin
    st0_nxt.sum  = sum;
    st0_nxt.zero = (sum == '0);
    for (int l = 0; l < 4; l++) begin
      st0_nxt.rem[l] = {w_in[l], 15'b0} + NRW'(sum >> 1);
      st0_nxt.q[l]   = '0;
    end
  end

  always_comb begin
    for (int i = 1; i <= NQB; i++) begin
      st_nxt[i] = ndiv_step(st_r[i-1], NQB - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
      for (int i = 1; i <= NQB; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NQB; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= NQB; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_comb begin
    if (st_r[NQB].zero) begin
      w_out[0] = W_ONE;
      w_out[1] = '0;
      w_out[2] = '0;
      w_out[3] = '0;
    end else begin
      w_out = st_r[NQB].q;
    end
  end

  assign out_vld = vld_r[NQB];

endmodule

### rtl/terrain_splat_blend_weights_unit.sv
// Top level of the terrain splat blend weights unit
`timescale 1ns / 1ps
// Usage:
// Input channel: in_valid / in_stall with in_up_dot (Q1.15) and in_height
//   (signed Q16.8). An item is taken at a clock edge with in_valid high and
//   in_stall low.
// Output channel: out_valid / out_stall with the four Q1.15 weights.
// Configuration: cfg_we, cfg_idx, cfg_wdata write one band register per
//   cycle; write only while no item is in flight. Indexes above five are
//   ignored.
// Pipeline: the ramp units (setup, 15 quotient-bit stages, two multiply
//   stages), then the mixer, then the normalizer (setup and 16 quotient-bit
//   stages).
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined dividers.
// Reset: synchronous rst_n clears all valid bits and loads the default
//   band registers; the pipeline is empty after reset.
// Stall: while out_valid and out_stall are high the whole pipeline holds,
//   in_stall is raised and the waiting result stays on the output.
module terrain_splat_blend_weights_unit import tsbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WW-1:0]        in_up_dot,
  input  logic signed [HW-1:0] in_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WW-1:0]        out_grass_weight,
  output logic [WW-1:0]        out_rock_weight,
  output logic [WW-1:0]        out_snow_weight,
  output logic [WW-1:0]        out_sand_weight,
  input  logic                 cfg_we,
  input  logic [IW-1:0]        cfg_idx,
  input  logic [CW-1:0]        cfg_wdata
);

  logic [15:0]        rock_lo_r, rock_hi_r;
  logic signed [23:0] snow_lo_r, snow_hi_r, sand_top_r;
  logic [22:0]        sand_wid_r;
  logic               en, acc;
  logic signed [RXW-1:0] rock_e0, rock_e1, rock_x;
  logic signed [RXW-1:0] snow_e0, snow_e1, hgt_x;
  logic signed [RXW-1:0] sand_e0, sand_e1;
  logic               ramp_vld, mix_vld;
  logic [WW-1:0]      sr, ss, sd;
  logic [3:0][WW-1:0] mix_w, norm_w;
  logic [NSW-1:0]     mix_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rock_lo_r  <= 16'd22938;
      rock_hi_r  <= 16'd29491;
      snow_lo_r  <= 24'sd25600;
      snow_hi_r  <= 24'sd38400;
      sand_top_r <= 24'sd512;
      sand_wid_r <= 23'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROCK_LO:  rock_lo_r  <= cfg_wdata[15:0];
        CFG_ROCK_HI:  rock_hi_r  <= cfg_wdata[15:0];
        CFG_SNOW_LO:  snow_lo_r  <= cfg_wdata;
        CFG_SNOW_HI:  snow_hi_r  <= cfg_wdata;
        CFG_SAND_TOP: sand_top_r <= cfg_wdata;
        CFG_SAND_WID: sand_wid_r <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign rock_e0 = $signed({11'b0, rock_lo_r});
  assign rock_e1 = $signed({11'b0, rock_hi_r});
  assign rock_x  = $signed({11'b0, in_up_dot});
  assign snow_e0 = RXW'(snow_lo_r);
  assign snow_e1 = RXW'(snow_hi_r);
  assign hgt_x   = RXW'(in_height);
  assign sand_e1 = RXW'(sand_top_r);
  assign sand_e0 = RXW'(sand_top_r) - $signed({4'b0, sand_wid_r});

  tsbw_ramp u_rock (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(acc),
    .e0(rock_e0), .e1(rock_e1), .x(rock_x),
    .out_vld(ramp_vld), .s(sr)
  );

  tsbw_ramp u_snow (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(acc),
    .e0(snow_e0), .e1(snow_e1), .x(hgt_x),
    .out_vld(), .s(ss)
  );

  tsbw_ramp u_sand (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(acc),
    .e0(sand_e0), .e1(sand_e1), .x(hgt_x),
    .out_vld(), .s(sd)
  );

  tsbw_mix u_mix (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(ramp_vld),
    .sr(sr), .ss(ss), .sd(sd),
    .out_vld(mix_vld), .w(mix_w), .sum(mix_sum)
  );

  tsbw_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(mix_vld),
    .w_in(mix_w), .sum(mix_sum),
    .out_vld(out_valid), .w_out(norm_w)
  );

  assign out_grass_weight = norm_w[0];
  assign out_rock_weight  = norm_w[1];
  assign out_snow_weight  = norm_w[2];
  assign out_sand_weight  = norm_w[3];

endmodule

### rtl/tsbw_chk.sv
// Port checker for the terrain splat blend weights unit and its bind
`timescale 1ns / 1ps
`include "terrain_splat_blend_weights_unit_macros.svh"
module tsbw_chk import tsbw_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [WW-1:0] out_grass_weight,
  input logic [WW-1:0] out_rock_weight,
  input logic [WW-1:0] out_snow_weight,
  input logic [WW-1:0] out_sand_weight
);

  `TSBW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `TSBW_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall mismatch")
  `TSBW_ASSERT(a_range, out_valid |-> out_grass_weight <= W_ONE && out_rock_weight <= W_ONE && out_snow_weight <= W_ONE && out_sand_weight <= W_ONE, "weight above one")
  `TSBW_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind terrain_splat_blend_weights_unit tsbw_chk u_tsbw_chk (.*);
